// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Immediate-consequence and next-cycle property checks on aclk with
// aresetn held low disabling the check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSIA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSIA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/rsia_pkg.sv -----
// ----------------------------------------------------------------------------
// rsia_pkg
// Widths, constants, register codes and the command and status types shared
// by the strength index controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rsia_pkg;

    localparam int SAMPLE_WIDTH    = 32;
    localparam int MEAN_WIDTH      = 48;
    localparam int INDEX_WIDTH     = 15;
    localparam int PERIOD_WIDTH    = 8;
    localparam int COUNT_WIDTH     = 32;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 15;
    localparam int NUM_WIDTH       = MEAN_WIDTH + INDEX_WIDTH;
    localparam int STEP_WIDTH      = $clog2(MEAN_WIDTH);

    typedef logic [INDEX_WIDTH-1:0]     index_t;
    typedef logic [MEAN_WIDTH-1:0]      mean_t;
    typedef logic [PERIOD_WIDTH-1:0]    period_t;
    typedef logic [STEP_WIDTH-1:0]      step_t;
    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

    localparam index_t  INDEX_FULL    = INDEX_WIDTH'(25600);
    localparam index_t  INDEX_MID     = INDEX_WIDTH'(12800);
    localparam index_t  INDEX_NO_LOSS = INDEX_WIDTH'(25347);
    localparam period_t PERIOD_RESET  = PERIOD_WIDTH'(14);
    localparam index_t  HIGH_RESET    = INDEX_WIDTH'(17920);
    localparam index_t  LOW_RESET     = INDEX_WIDTH'(7680);

    localparam cfg_index_t REG_PERIOD = CFG_INDEX_WIDTH'(0);
    localparam cfg_index_t REG_HIGH   = CFG_INDEX_WIDTH'(1);
    localparam cfg_index_t REG_LOW    = CFG_INDEX_WIDTH'(2);

    localparam step_t PDIV_LAST = STEP_WIDTH'(MEAN_WIDTH - 1);
    localparam step_t IDIV_LAST = STEP_WIDTH'(INDEX_WIDTH - 1);

    typedef struct packed {
        logic cfg_write;
        logic take_in;
        logic clear_all;
        logic seed;
        logic delta;
        logic accum;
        logic div_load;
        logic wild_load;
        logic pdiv_step;
        logic mean_wb;
        logic scale;
        logic idiv_step;
        logic index_wb;
        logic out_load;
    } rsia_cmd_t;

    typedef struct packed {
        logic op_clear;
        logic seeded;
        logic warm_active;
        logic warm_last;
    } rsia_status_t;

endpackage

`default_nettype wire

// ----- sv/relative_strength_index_alarm.sv -----
// ----------------------------------------------------------------------------
// relative_strength_index_alarm
// Wilder-smoothed relative strength index over signed fixed-point samples,
// with overbought and oversold levels and rising-edge alarms.
// ----------------------------------------------------------------------------
// One request is handled at a time and each gives exactly one result. A clear
// or the first sample after a clear goes from the prepare state straight to
// the output state, a warmup sample that does not complete the warmup also
// passes the accumulate state, and every sample that produces a fresh index
// has its means divided by the period in a two-lane bit-serial divider and
// then gets its index from a serial divider. A finished result waits in the
// output register while the next request is accepted. Configuration writes
// are accepted only between requests, and any write to a listed register
// restarts the warmup.
`default_nettype none

`include "assert_macros.svh"

module relative_strength_index_alarm (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic                                     s_valid,
    output logic                                          s_ready,
    input  wire logic                                     s_operation,
    input  wire logic signed [rsia_pkg::SAMPLE_WIDTH-1:0] s_sample,
    output logic                                          m_valid,
    input  wire logic                                     m_ready,
    output logic [rsia_pkg::INDEX_WIDTH-1:0]              m_index_value,
    output logic                                          m_index_valid,
    output logic                                          m_overbought_level,
    output logic                                          m_oversold_level,
    output logic                                          m_overbought_rise,
    output logic                                          m_oversold_rise,
    output logic [rsia_pkg::COUNT_WIDTH-1:0]              m_sample_count,
    input  wire logic                                     cfg_valid,
    output logic                                          cfg_ready,
    input  wire logic [rsia_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  wire logic [rsia_pkg::CFG_DATA_WIDTH-1:0]      cfg_data
);
    import rsia_pkg::*;

    rsia_cmd_t    cmd;
    rsia_status_t status;

    rsia_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    rsia_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .s_operation        (s_operation),
        .s_sample           (s_sample),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .m_index_value      (m_index_value),
        .m_index_valid      (m_index_valid),
        .m_overbought_level (m_overbought_level),
        .m_oversold_level   (m_oversold_level),
        .m_overbought_rise  (m_overbought_rise),
        .m_oversold_rise    (m_oversold_rise),
        .m_sample_count     (m_sample_count)
    );

    `RSIA_ASSERT_NOW(a_index_range, m_valid, m_index_value <= INDEX_FULL, "index over range")
    `RSIA_ASSERT_NOW(a_ob_rise_fresh, m_valid && m_overbought_rise, m_index_valid, "stale alarm")
    `RSIA_ASSERT_NOW(a_os_rise_fresh, m_valid && m_oversold_rise, m_index_valid, "stale alarm")
    `RSIA_ASSERT_NOW(a_ob_level, m_valid && m_overbought_rise, m_overbought_level, "no level")
    `RSIA_ASSERT_NEXT(a_one_request, s_valid && s_ready, !s_ready, "request accepted while busy")

endmodule

`default_nettype wire

// ----- sv/rsia_ctrl.sv -----
// ----------------------------------------------------------------------------
// rsia_ctrl
// Sequencer for the strength index: handshakes, step counting for the serial
// dividers and the command word that drives the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module rsia_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire rsia_pkg::rsia_status_t status,
    output rsia_pkg::rsia_cmd_t       cmd
);
    import rsia_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREP  = 4'd1;
    localparam logic [3:0] S_ACC   = 4'd2;
    localparam logic [3:0] S_PDIV  = 4'd3;
    localparam logic [3:0] S_MEAN  = 4'd4;
    localparam logic [3:0] S_SCALE = 4'd5;
    localparam logic [3:0] S_IDIV  = 4'd6;
    localparam logic [3:0] S_INDEX = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0] state_reg, state_next;
    step_t      step_reg, step_next;
    logic       m_valid_reg, m_valid_next;
    logic       idle;

    assign idle      = (state_reg == S_IDLE);
    assign cfg_ready = idle;
    assign s_ready   = idle && !cfg_valid;
    assign m_valid   = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            S_IDLE: begin
                if (cfg_valid) begin
                    cmd.cfg_write = 1'b1;
                end else if (s_valid) begin
                    cmd.take_in = 1'b1;
                    state_next  = S_PREP;
                end
            end
            S_PREP: begin
                if (status.op_clear) begin
                    cmd.clear_all = 1'b1;
                    state_next    = S_OUT;
                end else if (!status.seeded) begin
                    cmd.seed   = 1'b1;
                    state_next = S_OUT;
                end else begin
                    cmd.delta  = 1'b1;
                    state_next = S_ACC;
                end
            end
            S_ACC: begin
                step_next = '0;
                if (status.warm_active) begin
                    cmd.accum = 1'b1;
                    if (status.warm_last) begin
                        cmd.div_load = 1'b1;
                        state_next   = S_PDIV;
                    end else begin
                        state_next = S_OUT;
                    end
                end else begin
                    cmd.wild_load = 1'b1;
                    state_next    = S_PDIV;
                end
            end
            S_PDIV: begin
                cmd.pdiv_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == PDIV_LAST) begin
                    state_next = S_MEAN;
                end
            end
            S_MEAN: begin
                cmd.mean_wb = 1'b1;
                state_next  = S_SCALE;
            end
            S_SCALE: begin
                cmd.scale  = 1'b1;
                step_next  = '0;
                state_next = S_IDIV;
            end
            S_IDIV: begin
                cmd.idiv_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == IDIV_LAST) begin
                    state_next = S_INDEX;
                end
            end
            S_INDEX: begin
                cmd.index_wb = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/rsia_datapath.sv -----
// ----------------------------------------------------------------------------
// rsia_datapath
// Configuration registers, running means, a two-lane bit-serial divider by
// the period, a serial index divider, threshold flags and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rsia_datapath (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire rsia_pkg::rsia_cmd_t                    cmd,
    output rsia_pkg::rsia_status_t                      status,
    input  wire logic                                   s_operation,
    input  wire logic signed [rsia_pkg::SAMPLE_WIDTH-1:0] s_sample,
    input  wire logic [rsia_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  wire logic [rsia_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
    output logic [rsia_pkg::INDEX_WIDTH-1:0]            m_index_value,
    output logic                                        m_index_valid,
    output logic                                        m_overbought_level,
    output logic                                        m_oversold_level,
    output logic                                        m_overbought_rise,
    output logic                                        m_oversold_rise,
    output logic [rsia_pkg::COUNT_WIDTH-1:0]            m_sample_count
);
    import rsia_pkg::*;

    // Control and running state.
    period_t                 period_reg, period_next;
    index_t                  high_reg, high_next;
    index_t                  low_reg, low_next;
    logic                    seeded_reg, seeded_next;
    period_t                 warm_reg, warm_next;
    mean_t                   gmean_reg, gmean_next;
    mean_t                   lmean_reg, lmean_next;
    logic                    was_ob_reg, was_ob_next;
    logic                    was_os_reg, was_os_next;
    index_t                  held_reg, held_next;
    logic                    ob_level_reg, ob_level_next;
    logic                    os_level_reg, os_level_next;
    logic [COUNT_WIDTH-1:0]  count_reg, count_next;
    logic signed [SAMPLE_WIDTH-1:0] last_reg, last_next;

    // Working registers.
    logic                    op_reg, op_next;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg, sample_next;
    logic [SAMPLE_WIDTH-1:0] gain_reg, gain_next;
    logic [SAMPLE_WIDTH-1:0] loss_reg, loss_next;
    logic                    warm_mode_reg, warm_mode_next;
    logic                    gain_up_reg, gain_up_next;
    logic                    loss_up_reg, loss_up_next;
    mean_t                   gq_reg, gq_next;
    mean_t                   lq_reg, lq_next;
    period_t                 gr_reg, gr_next;
    period_t                 lr_reg, lr_next;
    mean_t                   rem_reg, rem_next;
    index_t                  iq_reg, iq_next;
    mean_t                   den_reg, den_next;
    logic                    special_reg, special_next;
    index_t                  special_idx_reg, special_idx_next;
    logic                    fresh_reg, fresh_next;
    logic                    ob_rise_reg, ob_rise_next;
    logic                    os_rise_reg, os_rise_next;

    // Result register.
    index_t                  out_index_reg, out_index_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_ob_reg, out_ob_next;
    logic                    out_os_reg, out_os_next;
    logic                    out_ob_rise_reg, out_ob_rise_next;
    logic                    out_os_rise_reg, out_os_rise_next;
    logic [COUNT_WIDTH-1:0]  out_count_reg, out_count_next;

    // Combinational helpers.
    period_t                 p_eff;
    logic                    cfg_hit;
    logic [SAMPLE_WIDTH:0]   delta, delta_neg;
    logic [MEAN_WIDTH:0]     gsum, lsum;
    mean_t                   gsum_sat, lsum_sat;
    mean_t                   gain_x, loss_x;
    logic                    gain_up, loss_up;
    mean_t                   gdiff, ldiff;
    logic [PERIOD_WIDTH:0]   gtrial, ltrial;
    logic                    gge, lge;
    logic                    halve;
    mean_t                   gs, ls, dsum;
    logic [NUM_WIDTH-1:0]    num;
    logic [MEAN_WIDTH:0]     itrial;
    logic                    ige;
    index_t                  new_index;
    logic                    ob_now, os_now;

    assign p_eff   = (period_reg == '0) ? PERIOD_WIDTH'(1) : period_reg;
    assign cfg_hit = (cfg_index == REG_PERIOD) || (cfg_index == REG_HIGH)
                     || (cfg_index == REG_LOW);

    assign delta     = {sample_reg[SAMPLE_WIDTH-1], sample_reg}
                       - {last_reg[SAMPLE_WIDTH-1], last_reg};
    assign delta_neg = '0 - delta;

    assign gsum     = {1'b0, gmean_reg} + (MEAN_WIDTH + 1)'(gain_reg);
    assign lsum     = {1'b0, lmean_reg} + (MEAN_WIDTH + 1)'(loss_reg);
    assign gsum_sat = gsum[MEAN_WIDTH] ? '1 : gsum[MEAN_WIDTH-1:0];
    assign lsum_sat = lsum[MEAN_WIDTH] ? '1 : lsum[MEAN_WIDTH-1:0];

    assign gain_x  = MEAN_WIDTH'(gain_reg);
    assign loss_x  = MEAN_WIDTH'(loss_reg);
    assign gain_up = gain_x >= gmean_reg;
    assign loss_up = loss_x >= lmean_reg;
    assign gdiff   = gain_up ? gain_x - gmean_reg : gmean_reg - gain_x;
    assign ldiff   = loss_up ? loss_x - lmean_reg : lmean_reg - loss_x;

    assign gtrial = {gr_reg, gq_reg[MEAN_WIDTH-1]};
    assign ltrial = {lr_reg, lq_reg[MEAN_WIDTH-1]};
    assign gge    = gtrial >= {1'b0, p_eff};
    assign lge    = ltrial >= {1'b0, p_eff};

    assign halve = gmean_reg[MEAN_WIDTH-1] || lmean_reg[MEAN_WIDTH-1];
    assign gs    = halve ? gmean_reg >> 1 : gmean_reg;
    assign ls    = halve ? lmean_reg >> 1 : lmean_reg;
    assign dsum  = gs + ls;
    assign num   = NUM_WIDTH'(gs) * NUM_WIDTH'(INDEX_FULL) + NUM_WIDTH'(dsum >> 1);

    assign itrial = {rem_reg, iq_reg[INDEX_WIDTH-1]};
    assign ige    = itrial >= {1'b0, den_reg};

    assign new_index = special_reg ? special_idx_reg : iq_reg;
    assign ob_now    = new_index > high_reg;
    assign os_now    = new_index < low_reg;

    assign status.op_clear    = op_reg;
    assign status.seeded      = seeded_reg;
    assign status.warm_active = warm_reg < p_eff;
    assign status.warm_last   = ((PERIOD_WIDTH + 1)'(warm_reg) + 1'b1)
                                == (PERIOD_WIDTH + 1)'(p_eff);

    always_comb begin
        period_next      = period_reg;
        high_next        = high_reg;
        low_next         = low_reg;
        seeded_next      = seeded_reg;
        warm_next        = warm_reg;
        gmean_next       = gmean_reg;
        lmean_next       = lmean_reg;
        was_ob_next      = was_ob_reg;
        was_os_next      = was_os_reg;
        held_next        = held_reg;
        ob_level_next    = ob_level_reg;
        os_level_next    = os_level_reg;
        count_next       = count_reg;
        last_next        = last_reg;
        op_next          = op_reg;
        sample_next      = sample_reg;
        gain_next        = gain_reg;
        loss_next        = loss_reg;
        warm_mode_next   = warm_mode_reg;
        gain_up_next     = gain_up_reg;
        loss_up_next     = loss_up_reg;
        gq_next          = gq_reg;
        lq_next          = lq_reg;
        gr_next          = gr_reg;
        lr_next          = lr_reg;
        rem_next         = rem_reg;
        iq_next          = iq_reg;
        den_next         = den_reg;
        special_next     = special_reg;
        special_idx_next = special_idx_reg;
        fresh_next       = fresh_reg;
        ob_rise_next     = ob_rise_reg;
        os_rise_next     = os_rise_reg;
        out_index_next   = out_index_reg;
        out_valid_next   = out_valid_reg;
        out_ob_next      = out_ob_reg;
        out_os_next      = out_os_reg;
        out_ob_rise_next = out_ob_rise_reg;
        out_os_rise_next = out_os_rise_reg;
        out_count_next   = out_count_reg;

        if (cmd.cfg_write) begin
            case (cfg_index)
                REG_PERIOD: period_next = cfg_data[PERIOD_WIDTH-1:0];
                REG_HIGH:   high_next   = cfg_data[INDEX_WIDTH-1:0];
                REG_LOW:    low_next    = cfg_data[INDEX_WIDTH-1:0];
                default:    ;
            endcase
        end

        if ((cmd.cfg_write && cfg_hit) || cmd.clear_all) begin
            last_next   = '0;
            seeded_next = 1'b0;
            warm_next   = '0;
            gmean_next  = '0;
            lmean_next  = '0;
            was_ob_next = 1'b0;
            was_os_next = 1'b0;
        end

        if (cmd.clear_all) begin
            held_next     = INDEX_MID;
            ob_level_next = 1'b0;
            os_level_next = 1'b0;
            count_next    = '0;
        end

        if (cmd.take_in) begin
            op_next      = s_operation;
            sample_next  = s_sample;
            fresh_next   = 1'b0;
            ob_rise_next = 1'b0;
            os_rise_next = 1'b0;
        end

        if (cmd.seed) begin
            count_next  = count_reg + 1'b1;
            last_next   = sample_reg;
            seeded_next = 1'b1;
        end

        if (cmd.delta) begin
            count_next = count_reg + 1'b1;
            last_next  = sample_reg;
            gain_next  = (!delta[SAMPLE_WIDTH] && (delta != '0))
                         ? delta[SAMPLE_WIDTH-1:0] : '0;
            loss_next  = delta[SAMPLE_WIDTH] ? delta_neg[SAMPLE_WIDTH-1:0] : '0;
        end

        if (cmd.accum) begin
            gmean_next = gsum_sat;
            lmean_next = lsum_sat;
            warm_next  = warm_reg + 1'b1;
        end

        if (cmd.div_load) begin
            warm_mode_next = 1'b1;
            gq_next        = gsum_sat;
            lq_next        = lsum_sat;
            gr_next        = '0;
            lr_next        = '0;
        end

        if (cmd.wild_load) begin
            warm_mode_next = 1'b0;
            gain_up_next   = gain_up;
            loss_up_next   = loss_up;
            gq_next        = gdiff;
            lq_next        = ldiff;
            gr_next        = '0;
            lr_next        = '0;
        end

        if (cmd.pdiv_step) begin
            gr_next = gge ? PERIOD_WIDTH'(gtrial - {1'b0, p_eff}) : gtrial[PERIOD_WIDTH-1:0];
            lr_next = lge ? PERIOD_WIDTH'(ltrial - {1'b0, p_eff}) : ltrial[PERIOD_WIDTH-1:0];
            gq_next = {gq_reg[MEAN_WIDTH-2:0], gge};
            lq_next = {lq_reg[MEAN_WIDTH-2:0], lge};
        end

        if (cmd.mean_wb) begin
            if (warm_mode_reg) begin
                gmean_next = gq_reg;
                lmean_next = lq_reg;
            end else begin
                gmean_next = gain_up_reg ? gmean_reg + gq_reg : gmean_reg - gq_reg;
                lmean_next = loss_up_reg ? lmean_reg + lq_reg : lmean_reg - lq_reg;
            end
        end

        if (cmd.scale) begin
            special_next     = (lmean_reg == '0);
            special_idx_next = (gmean_reg != '0) ? INDEX_NO_LOSS : INDEX_MID;
            den_next         = dsum;
            rem_next         = num[NUM_WIDTH-1 -: MEAN_WIDTH];
            iq_next          = num[INDEX_WIDTH-1:0];
        end

        if (cmd.idiv_step) begin
            rem_next = ige ? MEAN_WIDTH'(itrial - {1'b0, den_reg})
                           : itrial[MEAN_WIDTH-1:0];
            iq_next  = {iq_reg[INDEX_WIDTH-2:0], ige};
        end

        if (cmd.index_wb) begin
            held_next     = new_index;
            ob_level_next = ob_now;
            os_level_next = os_now;
            ob_rise_next  = ob_now && !was_ob_reg;
            os_rise_next  = os_now && !was_os_reg;
            was_ob_next   = ob_now;
            was_os_next   = os_now;
            fresh_next    = 1'b1;
        end

        if (cmd.out_load) begin
            out_index_next   = held_reg;
            out_valid_next   = fresh_reg;
            out_ob_next      = ob_level_reg;
            out_os_next      = os_level_reg;
            out_ob_rise_next = ob_rise_reg;
            out_os_rise_next = os_rise_reg;
            out_count_next   = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg   <= PERIOD_RESET;
            high_reg     <= HIGH_RESET;
            low_reg      <= LOW_RESET;
            seeded_reg   <= 1'b0;
            warm_reg     <= '0;
            gmean_reg    <= '0;
            lmean_reg    <= '0;
            was_ob_reg   <= 1'b0;
            was_os_reg   <= 1'b0;
            held_reg     <= INDEX_MID;
            ob_level_reg <= 1'b0;
            os_level_reg <= 1'b0;
            count_reg    <= '0;
            last_reg     <= '0;
            op_reg       <= 1'b0;
            fresh_reg    <= 1'b0;
            ob_rise_reg  <= 1'b0;
            os_rise_reg  <= 1'b0;
        end else begin
            period_reg   <= period_next;
            high_reg     <= high_next;
            low_reg      <= low_next;
            seeded_reg   <= seeded_next;
            warm_reg     <= warm_next;
            gmean_reg    <= gmean_next;
            lmean_reg    <= lmean_next;
            was_ob_reg   <= was_ob_next;
            was_os_reg   <= was_os_next;
            held_reg     <= held_next;
            ob_level_reg <= ob_level_next;
            os_level_reg <= os_level_next;
            count_reg    <= count_next;
            last_reg     <= last_next;
            op_reg       <= op_next;
            fresh_reg    <= fresh_next;
            ob_rise_reg  <= ob_rise_next;
            os_rise_reg  <= os_rise_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg      <= sample_next;
        gain_reg        <= gain_next;
        loss_reg        <= loss_next;
        warm_mode_reg   <= warm_mode_next;
        gain_up_reg     <= gain_up_next;
        loss_up_reg     <= loss_up_next;
        gq_reg          <= gq_next;
        lq_reg          <= lq_next;
        gr_reg          <= gr_next;
        lr_reg          <= lr_next;
        rem_reg         <= rem_next;
        iq_reg          <= iq_next;
        den_reg         <= den_next;
        special_reg     <= special_next;
        special_idx_reg <= special_idx_next;
        out_index_reg   <= out_index_next;
        out_valid_reg   <= out_valid_next;
        out_ob_reg      <= out_ob_next;
        out_os_reg      <= out_os_next;
        out_ob_rise_reg <= out_ob_rise_next;
        out_os_rise_reg <= out_os_rise_next;
        out_count_reg   <= out_count_next;
    end

    assign m_index_value      = out_index_reg;
    assign m_index_valid      = out_valid_reg;
    assign m_overbought_level = out_ob_reg;
    assign m_oversold_level   = out_os_reg;
    assign m_overbought_rise  = out_ob_rise_reg;
    assign m_oversold_rise    = out_os_rise_reg;
    assign m_sample_count     = out_count_reg;

endmodule

`default_nettype wire

// ----- tb/relative_strength_index_alarm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relative_strength_index_alarm_checker
// Watches the request, result and register channels of the strength index
// block, predicts every result from its own model of the smoothing, index and
// alarm logic, and compares each result field by field in order.
// ----------------------------------------------------------------------------
module relative_strength_index_alarm_checker #(
    parameter logic CLEAR_CODE = 1'b1
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    input  logic                                     s_ready,
    input  logic                                     s_operation,
    input  logic signed [rsia_pkg::SAMPLE_WIDTH-1:0] s_sample,
    input  logic                                     m_valid,
    input  logic                                     m_ready,
    input  rsia_pkg::index_t                         m_index_value,
    input  logic                                     m_index_valid,
    input  logic                                     m_overbought_level,
    input  logic                                     m_oversold_level,
    input  logic                                     m_overbought_rise,
    input  logic                                     m_oversold_rise,
    input  logic [rsia_pkg::COUNT_WIDTH-1:0]         m_sample_count,
    input  logic                                     cfg_valid,
    input  logic                                     cfg_ready,
    input  rsia_pkg::cfg_index_t                     cfg_index,
    input  logic [rsia_pkg::CFG_DATA_WIDTH-1:0]      cfg_data,
    output int                                       errors,
    output int                                       pending
);
    import rsia_pkg::*;

    typedef struct packed {
        index_t                 index_value;
        logic                   fresh;
        logic                   overbought;
        logic                   oversold;
        logic                   overbought_rise;
        logic                   oversold_rise;
        logic [COUNT_WIDTH-1:0] count;
    } reading_t;

    localparam logic [63:0] MEAN_LIMIT = (64'd1 << MEAN_WIDTH) - 64'd1;
    localparam logic [63:0] HALVE_LIMIT = 64'd1 << 47;

    reading_t expected_readings[$];

    period_t                period_reg;
    index_t                 high_reg;
    index_t                 low_reg;
    longint                 prev_sample;
    bit                     seeded;
    int                     warm_count;
    logic [63:0]            gain_avg;
    logic [63:0]            loss_avg;
    bit                     was_high;
    bit                     was_low;
    index_t                 held_index;
    bit                     high_level;
    bit                     low_level;
    logic [COUNT_WIDTH-1:0] seen_count;

    function automatic void restart_warmup();
        prev_sample = 0;
        seeded = 0;
        warm_count = 0;
        gain_avg = '0;
        loss_avg = '0;
        was_high = 0;
        was_low = 0;
    endfunction

    function automatic void clear_history();
        restart_warmup();
        held_index = INDEX_MID;
        high_level = 0;
        low_level = 0;
        seen_count = '0;
    endfunction

    function automatic logic [63:0] saturating_sum(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (s < a || s > MEAN_LIMIT) begin
            s = MEAN_LIMIT;
        end
        return s;
    endfunction

    function automatic logic [63:0] wilder_step(logic [63:0] avg, logic [63:0] x,
                                               logic [63:0] p);
        if (x >= avg) begin
            return avg + (x - avg) / p;
        end
        return avg - (avg - x) / p;
    endfunction

    function automatic index_t strength_of(logic [63:0] g, logic [63:0] l);
        logic [63:0] d;
        if (l == 0) begin
            return (g != 0) ? INDEX_NO_LOSS : INDEX_MID;
        end
        while (g >= HALVE_LIMIT || l >= HALVE_LIMIT) begin
            g = g >> 1;
            l = l >> 1;
        end
        d = g + l;
        if (d == 0) begin
            return INDEX_MID;
        end
        return index_t'((g * 64'(INDEX_FULL) + d / 2) / d);
    endfunction

    function automatic reading_t next_reading(logic op, logic signed [SAMPLE_WIDTH-1:0] smp);
        reading_t    r;
        longint      x;
        longint      delta;
        logic [63:0] gain;
        logic [63:0] loss;
        logic [63:0] p;
        bit          fresh;
        bit          high_now;
        bit          low_now;
        bit          high_rise;
        bit          low_rise;
        fresh = 0;
        high_rise = 0;
        low_rise = 0;
        if (op == CLEAR_CODE) begin
            clear_history();
        end else begin
            x = longint'(smp);
            seen_count = seen_count + 1'b1;
            if (!seeded) begin
                prev_sample = x;
                seeded = 1;
            end else begin
                delta = x - prev_sample;
                gain = (delta > 0) ? 64'(delta) : 64'd0;
                loss = (delta < 0) ? 64'(-delta) : 64'd0;
                p = (period_reg == 0) ? 64'd1 : 64'(period_reg);
                prev_sample = x;
                if (64'(warm_count) < p) begin
                    gain_avg = saturating_sum(gain_avg, gain);
                    loss_avg = saturating_sum(loss_avg, loss);
                    warm_count++;
                    if (64'(warm_count) == p) begin
                        gain_avg = gain_avg / p;
                        loss_avg = loss_avg / p;
                        fresh = 1;
                    end
                end else begin
                    gain_avg = wilder_step(gain_avg, gain, p);
                    loss_avg = wilder_step(loss_avg, loss, p);
                    fresh = 1;
                end
                if (fresh) begin
                    held_index = strength_of(gain_avg, loss_avg);
                    high_now = held_index > high_reg;
                    low_now = held_index < low_reg;
                    high_rise = high_now && !was_high;
                    low_rise = low_now && !was_low;
                    was_high = high_now;
                    was_low = low_now;
                    high_level = high_now;
                    low_level = low_now;
                end
            end
        end
        r.index_value = held_index;
        r.fresh = fresh;
        r.overbought = high_level;
        r.oversold = low_level;
        r.overbought_rise = high_rise;
        r.oversold_rise = low_rise;
        r.count = seen_count;
        return r;
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        reading_t want;
        if (!aresetn) begin
            period_reg = PERIOD_RESET;
            high_reg = HIGH_RESET;
            low_reg = LOW_RESET;
            clear_history();
            expected_readings.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_readings.size() == 0) begin
                    $display("%0t: result with no request outstanding, expected none, actual count %0d",
                             $time, m_sample_count);
                    errors++;
                end else begin
                    want = expected_readings.pop_front();
                    check_field("index_value", want.index_value, m_index_value);
                    check_field("index_valid", want.fresh, m_index_valid);
                    check_field("overbought_level", want.overbought, m_overbought_level);
                    check_field("oversold_level", want.oversold, m_oversold_level);
                    check_field("overbought_rise", want.overbought_rise, m_overbought_rise);
                    check_field("oversold_rise", want.oversold_rise, m_oversold_rise);
                    check_field("sample_count", want.count, m_sample_count);
                end
            end
            if (s_valid && s_ready) begin
                expected_readings.push_back(next_reading(s_operation, s_sample));
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_PERIOD: begin
                        period_reg = cfg_data[PERIOD_WIDTH-1:0];
                        restart_warmup();
                    end
                    REG_HIGH: begin
                        high_reg = cfg_data[INDEX_WIDTH-1:0];
                        restart_warmup();
                    end
                    REG_LOW: begin
                        low_reg = cfg_data[INDEX_WIDTH-1:0];
                        restart_warmup();
                    end
                    default: begin
                    end
                endcase
            end
        end
        pending = expected_readings.size();
    end

endmodule

// ----- tb/relative_strength_index_alarm_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relative_strength_index_alarm_tb
// Drives sample and clear requests and register writes into the strength
// index block under several idle and stall patterns, and reports the verdict
// of the checker that runs beside it.
// ----------------------------------------------------------------------------
module relative_strength_index_alarm_tb;
    import rsia_pkg::*;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR = 1'b1;
    localparam int CYCLE_LIMIT = 2000000;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    logic                           s_operation;
    logic signed [SAMPLE_WIDTH-1:0] s_sample;
    logic                           m_valid;
    logic                           m_ready;
    index_t                         m_index_value;
    logic                           m_index_valid;
    logic                           m_overbought_level;
    logic                           m_oversold_level;
    logic                           m_overbought_rise;
    logic                           m_oversold_rise;
    logic [COUNT_WIDTH-1:0]         m_sample_count;
    logic                           cfg_valid;
    logic                           cfg_ready;
    cfg_index_t                     cfg_index;
    logic [CFG_DATA_WIDTH-1:0]      cfg_data;

    int                             errors;
    int                             pending;
    int                             idle_pct;
    int                             stall_pct;
    int                             cycle_count;
    logic signed [SAMPLE_WIDTH-1:0] walk_level;

    relative_strength_index_alarm dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_operation        (s_operation),
        .s_sample           (s_sample),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_index_value      (m_index_value),
        .m_index_valid      (m_index_valid),
        .m_overbought_level (m_overbought_level),
        .m_oversold_level   (m_oversold_level),
        .m_overbought_rise  (m_overbought_rise),
        .m_oversold_rise    (m_oversold_rise),
        .m_sample_count     (m_sample_count),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    relative_strength_index_alarm_checker #(
        .CLEAR_CODE (OP_CLEAR)
    ) u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_operation        (s_operation),
        .s_sample           (s_sample),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_index_value      (m_index_value),
        .m_index_valid      (m_index_valid),
        .m_overbought_level (m_overbought_level),
        .m_oversold_level   (m_oversold_level),
        .m_overbought_rise  (m_overbought_rise),
        .m_oversold_rise    (m_oversold_rise),
        .m_sample_count     (m_sample_count),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .errors             (errors),
        .pending            (pending)
    );

    initial begin
        aclk = 1'b0;
    end

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= stall_pct);
    end

    task automatic push_request(input logic op, input logic signed [SAMPLE_WIDTH-1:0] smp);
        while ($urandom_range(99) < idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_operation = op;
        s_sample = smp;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_WIDTH-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    task automatic wait_idle(input int settle);
        s_valid = 1'b0;
        while (pending != 0) begin
            @(negedge aclk);
        end
        repeat (settle) @(negedge aclk);
    endtask

    task automatic configure(input int period, input int high, input int low);
        wait_idle(8);
        write_register(REG_PERIOD, CFG_DATA_WIDTH'(period));
        write_register(REG_HIGH, CFG_DATA_WIDTH'(high));
        write_register(REG_LOW, CFG_DATA_WIDTH'(low));
        cfg_valid = 1'b0;
    endtask

    // Mostly trending or sideways runs of samples, with occasional jumps and clears.
    task automatic run_random(input int total, input int clear_pct);
        int                             sent;
        int                             roll;
        int                             run_len;
        int                             shift;
        int                             trend;
        bit                             down;
        logic signed [SAMPLE_WIDTH-1:0] step;
        sent = 0;
        walk_level = $urandom;
        while (sent < total) begin
            roll = $urandom_range(99);
            if (roll < clear_pct) begin
                push_request(OP_CLEAR, $urandom);
                sent++;
            end else if (roll < clear_pct + 6) begin
                walk_level = $urandom;
                push_request(OP_SAMPLE, walk_level);
                sent++;
            end else begin
                run_len = $urandom_range(4, 40);
                shift = $urandom_range(0, 30);
                trend = $urandom_range(0, 2);
                for (int k = 0; k < run_len && sent < total; k++) begin
                    step = $urandom_range(0, 32'd1 << shift);
                    if (trend == 0) begin
                        down = $urandom_range(1);
                    end else begin
                        down = ($urandom_range(99) < 22) ^ (trend == 2);
                    end
                    walk_level = down ? walk_level - step : walk_level + step;
                    push_request(OP_SAMPLE, walk_level);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_operation = OP_SAMPLE;
        s_sample = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_PERIOD;
        cfg_data = '0;
        idle_pct = 0;
        stall_pct = 0;
        cycle_count = 0;
        walk_level = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset settings: flat warmup gives the no-movement index, then the
        // largest gain and the largest loss go through the smoothing step.
        push_request(OP_CLEAR, -1);
        push_request(OP_SAMPLE, 32'sh80000000);
        repeat (14) push_request(OP_SAMPLE, 32'sh80000000);
        push_request(OP_SAMPLE, 32'sh7FFFFFFF);
        push_request(OP_SAMPLE, 32'sh80000000);

        // Period of one: gain only, loss only, then no movement at all.
        wait_idle(8);
        write_register(REG_PERIOD, CFG_DATA_WIDTH'(1));
        cfg_valid = 1'b0;
        push_request(OP_SAMPLE, 5);
        push_request(OP_SAMPLE, 10);
        push_request(OP_SAMPLE, 3);
        push_request(OP_SAMPLE, 3);
        push_request(OP_CLEAR, 32'sh7FFFFFFF);

        idle_pct = 0;
        stall_pct = 0;
        configure(14, 17920, 7680);
        run_random(200, 2);
        configure(255, 0, 25600);
        run_random(330, 0);

        idle_pct = 87;
        stall_pct = 0;
        configure(1, 25600, 0);
        run_random(180, 2);
        configure(2, 12800, 12800);
        run_random(180, 2);

        idle_pct = 0;
        stall_pct = 87;
        configure(3, 20000, 5000);
        run_random(200, 2);
        configure($urandom_range(1, 8), $urandom_range(0, 25600), $urandom_range(0, 25600));
        run_random(180, 2);

        idle_pct = 24;
        stall_pct = 24;
        configure(5, 15000, 10000);
        run_random(150, 2);
        configure($urandom_range(1, 8), $urandom_range(0, 25600), $urandom_range(0, 25600));
        run_random(150, 2);

        wait_idle(100);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
